// ===== hdl/sinr_cqi_link_adaptation_assert.svh =====
// ----------------------------------------------------------------------------
// SINR to CQI link adaptation: assertion macros
// Clocked assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SINR_CQI_LINK_ADAPTATION_ASSERT_SVH
`define SINR_CQI_LINK_ADAPTATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property holds at every edge outside reset
`define SCQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition implies a consequence in the next cycle
`define SCQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`else

`define SCQ_ASSERT(label, clk, rst, prop)
`define SCQ_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

// ===== hdl/sinr_cqi_pkg.sv =====
// ----------------------------------------------------------------------------
// SINR to CQI package
// Types, CQI tables and the power-sum correction generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sinr_cqi_pkg;

   localparam int CQI_LEVELS = 16;

   // SINR saturation limits in 0.01 dB
   localparam logic signed [15:0] SINR_LOW  = -16'sd5000;
   localparam logic signed [15:0] SINR_HIGH = 16'sd30000;

   // modulation codes
   localparam logic [1:0] MOD_NONE  = 2'd0;
   localparam logic [1:0] MOD_QPSK  = 2'd1;
   localparam logic [1:0] MOD_16QAM = 2'd2;
   localparam logic [1:0] MOD_64QAM = 2'd3;

   // highest CQI of each modulation
   localparam logic [3:0] CQI_QPSK_TOP  = 4'd6;
   localparam logic [3:0] CQI_16QAM_TOP = 4'd9;

   // CQI thresholds in 0.01 dB; level zero is never tested
   localparam logic signed [15:0] CQI_THR [CQI_LEVELS] = '{
      -16'sd2000, -16'sd700, -16'sd500, -16'sd300,
      -16'sd100,  16'sd100,  16'sd300,  16'sd500,
      16'sd800,   16'sd1100, 16'sd1300, 16'sd1500,
      16'sd1700,  16'sd1900, 16'sd2100, 16'sd2300
   };

   // spectral efficiency in 0.0001 bps/Hz
   localparam logic [15:0] CQI_EFF [CQI_LEVELS] = '{
      16'd0,     16'd1523,  16'd2344,  16'd3770,
      16'd6016,  16'd8770,  16'd11758, 16'd14766,
      16'd19141, 16'd24063, 16'd27305, 16'd33223,
      16'd39023, 16'd45234, 16'd51152, 16'd55547
   };

   // fixed-point constants of the correction generator
   localparam logic [63:0] Q30_ONE   = 64'd1073741824;
   localparam logic [63:0] STEP_Q30  = 64'd1049300475;
   localparam logic [63:0] SCALE_Q20 = 64'd315652829;

   localparam int CORR_W = 9;

   // result mapping fields
   typedef struct packed {
      logic [3:0]  cqi;
      logic [3:0]  mcs;
      logic [1:0]  modulation;
      logic [15:0] efficiency;
   } cqi_info_type;

   // correction entry k: round(1000*log10(1 + 10^(-k/100))) in 0.01 dB,
   // evaluated at elaboration only
   function automatic logic [CORR_W-1:0] corr_value(input int unsigned k);
      logic [63:0] y;
      logic [63:0] v;
      logic [63:0] lg;
      logic [63:0] p;
      int unsigned i;
      y = Q30_ONE;
      for (i = 0; i < k; i++) begin
         y = (y * STEP_Q30 + (64'd1 << 29)) >> 30;
      end
      v  = Q30_ONE + y;
      lg = 64'd0;
      if (v >= (Q30_ONE << 1)) begin
         lg = Q30_ONE;
         v  = v >> 1;
      end
      // log2 one fraction bit per squaring
      for (i = 0; i < 30; i++) begin
         v = (v * v + (64'd1 << 29)) >> 30;
         if (v >= (Q30_ONE << 1)) begin
            lg = lg | (64'd1 << (29 - i));
            v  = v >> 1;
         end
      end
      p = (lg * SCALE_Q20 + (64'd1 << 49)) >> 50;
      return p[CORR_W-1:0];
   endfunction

endpackage

// ===== hdl/sinr_cqi_corr.sv =====
// ----------------------------------------------------------------------------
// SINR to CQI power sum
// dB-sum of interference and noise floor: larger operand plus table
// correction indexed by the rounded difference in 0.1 dB steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sinr_cqi_corr #(
   parameter int CORR_ENTRIES = 256
) (
   input  logic signed [15:0] interference,
   input  logic signed [15:0] noise_floor,
   output logic signed [16:0] power_sum
);

   localparam int IDX_W = $clog2(CORR_ENTRIES);
   localparam logic [13:0] ENTRIES_LIM = 14'(CORR_ENTRIES);
   // ceil(2^21 / 10): exact quotient for any 17-bit dividend
   localparam logic [17:0] RECIP_TEN = 18'd209716;

   logic [sinr_cqi_pkg::CORR_W-1:0] corr_rom [CORR_ENTRIES];

   logic signed [15:0] hi;
   logic signed [15:0] lo;
   logic signed [16:0] diff;
   logic [16:0]        diff_rnd;
   logic [34:0]        quot_prod;
   logic [12:0]        idx_full;
   logic               in_range;
   logic [sinr_cqi_pkg::CORR_W-1:0] corr;

   // build the correction table
   for (genvar k = 0; k < CORR_ENTRIES; k++) begin : g_rom
      localparam logic [sinr_cqi_pkg::CORR_W-1:0] ROM_VAL =
         sinr_cqi_pkg::corr_value(k);
      assign corr_rom[k] = ROM_VAL;
   end

   // order operands, form the rounded index and add the table correction
   always_comb begin
      if (interference > noise_floor) begin
         hi = interference;
         lo = noise_floor;
      end else begin
         hi = noise_floor;
         lo = interference;
      end
      diff      = 17'(hi) - 17'(lo);
      diff_rnd  = {1'b0, diff[15:0]} + 17'd5;
      quot_prod = 35'(diff_rnd) * 35'(RECIP_TEN);
      idx_full  = quot_prod[33:21];
      in_range  = ({1'b0, idx_full} < ENTRIES_LIM);
      corr      = in_range ? corr_rom[idx_full[IDX_W-1:0]] : '0;
      power_sum = 17'(hi) + $signed({8'd0, corr});
   end

endmodule

// ===== hdl/sinr_cqi_map.sv =====
// ----------------------------------------------------------------------------
// SINR to CQI mapping
// Threshold compare of saturated SINR, then MCS, modulation and efficiency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sinr_cqi_map (
   input  logic signed [15:0]          sinr,
   output sinr_cqi_pkg::cqi_info_type  info
);

   logic [3:0] cqi;

   // pick the highest threshold met; thresholds rise with level
   always_comb begin
      cqi = 4'd0;
      for (int i = 1; i < sinr_cqi_pkg::CQI_LEVELS; i++) begin
         if (sinr >= sinr_cqi_pkg::CQI_THR[i]) begin
            cqi = 4'(i);
         end
      end
   end

   // derive the remaining fields
   always_comb begin
      info.cqi        = cqi;
      info.mcs        = (cqi == 4'd0) ? 4'd1 : cqi;
      info.efficiency = sinr_cqi_pkg::CQI_EFF[cqi];
      if (cqi == 4'd0) begin
         info.modulation = sinr_cqi_pkg::MOD_NONE;
      end else if (cqi <= sinr_cqi_pkg::CQI_QPSK_TOP) begin
         info.modulation = sinr_cqi_pkg::MOD_QPSK;
      end else if (cqi <= sinr_cqi_pkg::CQI_16QAM_TOP) begin
         info.modulation = sinr_cqi_pkg::MOD_16QAM;
      end else begin
         info.modulation = sinr_cqi_pkg::MOD_64QAM;
      end
   end

endmodule

// ===== hdl/sinr_cqi_link_adaptation.sv =====
// Path: an item is held in the input register, then in the result register.
// Throughput: one item per cycle while the result channel is not stalled, set by the
// single pass of logic between the input register and the result register.
// Reset: synchronous, active high; clears both valid flags and sets the
// noise floor to -100 dBm.
// ----------------------------------------------------------------------------
// SINR to CQI link adaptation
// Forms SINR against interference plus noise and maps it to CQI, MCS,
// modulation and spectral efficiency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sinr_cqi_link_adaptation_assert.svh"

module sinr_cqi_link_adaptation #(
   parameter int CORR_ENTRIES = 256
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic signed [15:0] csr_write_data,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_rx_power,
   input  logic signed [15:0] req_interference,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sinr,
   output logic [3:0]         rsp_cqi,
   output logic [3:0]         rsp_mcs,
   output logic [1:0]         rsp_modulation,
   output logic [15:0]        rsp_efficiency
);

   localparam logic signed [15:0] NOISE_RESET = -16'sd10000;

   logic signed [15:0] noise_floor_ff;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic signed [15:0] rx_ff;
   logic signed [15:0] intf_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic signed [15:0] sinr_ff;
   logic signed [15:0] sinr_in;
   sinr_cqi_pkg::cqi_info_type info_ff;
   sinr_cqi_pkg::cqi_info_type info_in;

   logic               out_blocked;
   logic               s1_advance;
   logic               req_take;
   logic signed [16:0] power_sum;
   logic signed [17:0] sinr_full;

   // hold the noise floor register
   always_ff @(posedge clock) begin
      if (reset) begin
         noise_floor_ff <= NOISE_RESET;
      end else if (csr_write_enable) begin
         noise_floor_ff <= csr_write_data;
      end
   end

   // stall only when both stages are full and the result is not taken
   always_comb begin
      out_blocked  = rsp_valid_ff && rsp_stall;
      s1_advance   = !out_blocked;
      req_stall    = s1_valid_ff && out_blocked;
      req_take     = req_valid && !req_stall;
      s1_valid_in  = s1_advance ? req_take : (s1_valid_ff || req_take);
      rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rx_ff   <= req_rx_power;
         intf_ff <= req_interference;
      end
   end

   // interference plus noise
   sinr_cqi_corr #(
      .CORR_ENTRIES (CORR_ENTRIES)
   ) u_corr (
      .interference (intf_ff),
      .noise_floor  (noise_floor_ff),
      .power_sum    (power_sum)
   );

   // subtract and saturate
   always_comb begin
      sinr_full = 18'(rx_ff) - 18'(power_sum);
      if (sinr_full < 18'(sinr_cqi_pkg::SINR_LOW)) begin
         sinr_in = sinr_cqi_pkg::SINR_LOW;
      end else if (sinr_full > 18'(sinr_cqi_pkg::SINR_HIGH)) begin
         sinr_in = sinr_cqi_pkg::SINR_HIGH;
      end else begin
         sinr_in = sinr_full[15:0];
      end
   end

   sinr_cqi_map u_map (
      .sinr (sinr_in),
      .info (info_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_valid_ff) begin
         sinr_ff <= sinr_in;
         info_ff <= info_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sinr       = sinr_ff;
   assign rsp_cqi        = info_ff.cqi;
   assign rsp_mcs        = info_ff.mcs;
   assign rsp_modulation = info_ff.modulation;
   assign rsp_efficiency = info_ff.efficiency;

   // a free result stage always takes the waiting item
   `SCQ_ASSERT_NEXT(a_s1_moves, clock, reset, s1_valid_ff && !out_blocked, rsp_valid_ff)

   // a blocked input stage keeps its item
   `SCQ_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && out_blocked, s1_valid_ff && $stable(rx_ff) && $stable(intf_ff))

   // CQI zero exactly when SINR lies under the lowest tested threshold
   `SCQ_ASSERT(a_cqi_floor, clock, reset, !rsp_valid_ff || ((info_ff.cqi == 4'd0) == (sinr_ff < sinr_cqi_pkg::CQI_THR[1])))

endmodule
